// ----- rtl/bsa_pkg.sv -----
// Shared types and constants for the bitmap slot allocator.
// No dependencies; the interfaces, divider, core, checker and testbench import this package.
`default_nettype none
package bsa_pkg;

  localparam int unsigned OFFSET_W = 26;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ELEM_W   = 16;
  localparam int unsigned NB_W     = 8;
  localparam int unsigned SLOT_W   = 11;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALIGN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREE  = 3'd4;

  // Request codes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RECLAIM = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BITMAP_BYTES  = 1'b1;

  // Bit masks used to encode an isolated bit position
  localparam logic [7:0] SLOT0_BIT = 8'h80;
  localparam logic [7:0] MASK_POS4 = 8'h0f;
  localparam logic [7:0] MASK_POS2 = 8'h33;
  localparam logic [7:0] MASK_POS1 = 8'h55;
  localparam logic [7:0] BYTE_FREE = 8'hff;

  // Divider: two quotient bits per cycle
  localparam int unsigned DIV_STEPS = OFFSET_W / 2;
  localparam int unsigned DIV_CNT_W = 4;

endpackage
`default_nettype wire

// ----- rtl/bsa_if.sv -----
// Handshake channels for allocator requests and results.
// Depends on bsa_pkg for field widths.
`default_nettype none
interface bsa_in_if
  import bsa_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [OFFSET_W-1:0] region_offset;
  modport source (output valid, func, region_offset, input ready);
  modport sink (input valid, func, region_offset, output ready);
endinterface

interface bsa_out_if
  import bsa_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  slot_index;
  logic [OFFSET_W-1:0] slot_offset;
  modport source (output valid, status, slot_index, slot_offset, input ready);
  modport sink (input valid, status, slot_index, slot_offset, output ready);
endinterface
`default_nettype wire

// ----- rtl/bsa_map_ram.sv -----
// Free bitmap storage: one write port, one registered read port.
// Depends on nothing beyond its parameters.
`default_nettype none
module bsa_map_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bsa_divider.sv -----
// Restoring divider, two quotient bits per cycle, for reclaim offsets.
// Depends on bsa_pkg.
`default_nettype none
module bsa_divider
  import bsa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [OFFSET_W-1:0] dividend,
  input  wire logic [ELEM_W-1:0]   divisor,
  output logic                     busy,
  output logic [OFFSET_W-1:0]      quotient,
  output logic [ELEM_W-1:0]        remainder
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [ELEM_W-1:0]    dsr;
  logic [OFFSET_W-1:0]  quo_next;
  logic [ELEM_W-1:0]    rem_next;

  // Two shift-compare-subtract steps
  always_comb begin
    logic [ELEM_W:0] t;
    rem_next = remainder;
    quo_next = quotient;
    for (int k = 0; k < 2; k++) begin
      t = {rem_next, quo_next[OFFSET_W-1]};
      quo_next = {quo_next[OFFSET_W-2:0], 1'b0};
      if (t >= {1'b0, dsr}) begin
        rem_next = ELEM_W'(t - {1'b0, dsr});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = t[ELEM_W-1:0];
      end
    end
  end

  assign busy = (cnt != '0);

  // Load on start, then advance until the count runs out
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient  <= quo_next;
      remainder <= rem_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bitmap_slot_allocator_core.sv -----
// Allocate takes the next fresh slot, or scans bitmap bytes in order and reports no memory when
// all are full. Reclaim range checks the offset, then the divider (two quotient bits a cycle)
// checks alignment and finds the slot. One transaction is worked on at a time; a new one is
// taken while a result waits, and its own result is held until the output register is free.
// Synchronous active-high reset: state, configuration, fill count and output valid to defaults, every slot free.
// Bitmap entries are not cleared; a fill count of fresh slots marks written bytes.
`default_nettype none
module bitmap_slot_allocator_core
  import bsa_pkg::*;
#(
  parameter int unsigned MAP_BYTES = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  bsa_in_if.sink                    in_ch,
  bsa_out_if.source                 out_ch
);

  localparam int unsigned AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  typedef enum logic [3:0] {
    IDLE, A_RD, A_WR, S_RD, S_CHK, MUL_OFF, ADD_OFF,
    R_LIM, R_CMP, R_DIV, R_RD, R_WR, DONE
  } state_t;

  state_t state;

  logic [ELEM_W-1:0]   element_bytes;
  logic [NB_W-1:0]     bitmap_bytes;
  logic [SLOT_W-1:0]   fresh;
  logic [OFFSET_W-1:0] roff_r;
  logic [NB_W-1:0]     nb_r;
  logic [ELEM_W-1:0]   eb_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [NB_W-1:0]     scan_i;
  logic [26:0]         prod_r;
  logic [OFFSET_W-1:0] rel_r;
  logic                below_r;
  logic [STATUS_W-1:0] wk_status;
  logic [INDEX_W-1:0]  wk_index;
  logic [OFFSET_W-1:0] wk_offset;
  logic [STATUS_W-1:0] res_status;
  logic [INDEX_W-1:0]  res_index;
  logic [OFFSET_W-1:0] res_offset;
  logic                out_valid;

  logic [NB_W-1:0]     nb_now;
  logic [SLOT_W-1:0]   cap;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [7:0]          ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [7:0]          ram_rdata;
  logic [7:0]          cur_byte;
  logic [7:0]          low_bit;
  logic [2:0]          low_pos;
  logic [7:0]          slot_mask;
  logic                div_start;
  logic                div_busy;
  logic [OFFSET_W-1:0] div_quo;
  logic [ELEM_W-1:0]   div_rem;

  assign nb_now = (32'(bitmap_bytes) > MAP_BYTES) ? NB_W'(MAP_BYTES) : bitmap_bytes;
  assign cap    = {nb_r, 3'b000};

  bsa_map_ram #(.DEPTH(MAP_BYTES), .AW(AW)) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  bsa_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rel_r),
    .divisor  (eb_r),
    .busy     (div_busy),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // A byte is only valid once fresh allocation has reached into it
  assign cur_byte  = ({slot_r[SLOT_W-1:3], 3'b000} < fresh) ? ram_rdata : BYTE_FREE;
  assign slot_mask = SLOT0_BIT >> slot_r[2:0];
  assign low_bit   = ram_rdata & (~ram_rdata + 8'd1);
  assign low_pos   = {|(low_bit & MASK_POS4), |(low_bit & MASK_POS2),
                      |(low_bit & MASK_POS1)};
  assign div_start = (state == R_CMP) && !below_r && (27'(rel_r) < prod_r);

  // Memory port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = AW'(slot_r[SLOT_W-1:3]);
    ram_we    = 1'b0;
    ram_waddr = AW'(slot_r[SLOT_W-1:3]);
    ram_wdata = cur_byte & ~slot_mask;
    unique case (state)
      A_RD, R_RD: begin
        ram_re = 1'b1;
      end
      S_RD: begin
        ram_re    = (scan_i != nb_r);
        ram_raddr = AW'(scan_i);
      end
      A_WR: begin
        ram_we = 1'b1;
      end
      S_CHK: begin
        ram_we    = (ram_rdata != '0);
        ram_waddr = AW'(scan_i);
        ram_wdata = ram_rdata & ~low_bit;
      end
      R_WR: begin
        ram_we    = !(|(cur_byte & slot_mask));
        ram_wdata = cur_byte | slot_mask;
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready        = (state == IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.status      = res_status;
  assign out_ch.slot_index  = res_index;
  assign out_ch.slot_offset = res_offset;

  // Control state, configuration and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      element_bytes <= ELEM_W'(1);
      bitmap_bytes  <= NB_W'(128);
      fresh         <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ELEMENT_BYTES: element_bytes <= cfg_data[ELEM_W-1:0];
          REG_BITMAP_BYTES: begin
            bitmap_bytes <= cfg_data[NB_W-1:0];
            fresh        <= '0;
          end
          default: begin
          end
        endcase
      end
      // Raise the result once the output register is free, drop it once taken
      if ((state == DONE) && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_ch.valid) begin
            roff_r <= in_ch.region_offset;
            nb_r   <= nb_now;
            eb_r   <= (element_bytes == '0) ? ELEM_W'(1) : element_bytes;
            slot_r <= fresh;
            scan_i <= '0;
            if (in_ch.func == FUNC_RECLAIM) begin
              state <= R_LIM;
            end else if (fresh < {nb_now, 3'b000}) begin
              state <= A_RD;
            end else begin
              state <= S_RD;
            end
          end
        end
        A_RD: state <= A_WR;
        A_WR: begin
          fresh <= fresh + 1'b1;
          state <= MUL_OFF;
        end
        S_RD: begin
          if (scan_i == nb_r) begin
            wk_status <= ST_OOM;
            wk_index  <= '0;
            wk_offset <= '0;
            state     <= DONE;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (ram_rdata != '0) begin
            slot_r <= {scan_i, low_pos};
            state  <= MUL_OFF;
          end else begin
            scan_i <= scan_i + 1'b1;
            state  <= S_RD;
          end
        end
        MUL_OFF: begin
          prod_r <= 27'(slot_r) * 27'(eb_r);
          state  <= ADD_OFF;
        end
        ADD_OFF: begin
          wk_status <= ST_OK;
          wk_index  <= slot_r[INDEX_W-1:0];
          wk_offset <= OFFSET_W'(prod_r + 27'(nb_r));
          state     <= DONE;
        end
        R_LIM: begin
          prod_r  <= 27'(cap) * 27'(eb_r);
          rel_r   <= roff_r - OFFSET_W'(nb_r);
          below_r <= (roff_r < OFFSET_W'(nb_r));
          state   <= R_CMP;
        end
        R_CMP: begin
          if (div_start) begin
            state <= R_DIV;
          end else begin
            wk_status <= ST_RANGE;
            wk_index  <= '0;
            wk_offset <= '0;
            state     <= DONE;
          end
        end
        R_DIV: begin
          if (!div_busy) begin
            if (div_rem != '0) begin
              wk_status <= ST_ALIGN;
              wk_index  <= '0;
              wk_offset <= '0;
              state     <= DONE;
            end else begin
              slot_r <= div_quo[SLOT_W-1:0];
              state  <= R_RD;
            end
          end
        end
        R_RD: state <= R_WR;
        R_WR: begin
          wk_offset <= '0;
          if (|(cur_byte & slot_mask)) begin
            wk_status <= ST_FREE;
            wk_index  <= '0;
          end else begin
            wk_status <= ST_OK;
            wk_index  <= slot_r[INDEX_W-1:0];
          end
          state <= DONE;
        end
        // Hand the result over once the previous one has been taken
        DONE: begin
          if (!out_valid || out_ch.ready) begin
            res_status <= wk_status;
            res_index  <= wk_index;
            res_offset <= wk_offset;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bsa_checker.sv -----
// Port-level checks for the allocator core, bound into the allocator core.
// Depends on bsa_pkg and bitmap_slot_allocator_core.
`default_nettype none
module bsa_checker
  import bsa_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [INDEX_W-1:0]  slot_index,
  input wire logic [OFFSET_W-1:0] slot_offset
);

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  // Errors report zero slot and offset
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (slot_index == '0) && (slot_offset == '0))
    else $error("error result carries slot data");

  // Status code is one of the defined ones
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK) || (status == ST_OOM) || (status == ST_RANGE)
                  || (status == ST_ALIGN) || (status == ST_FREE))
    else $error("undefined status code");

  // Busy after taking a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .status     (out_ch.status),
  .slot_index (out_ch.slot_index),
  .slot_offset(out_ch.slot_offset)
);
`default_nettype wire

// ----- tb/bitmap_slot_allocator_core_tb.sv -----
// Testbench for bitmap_slot_allocator_core: directed and random allocate/reclaim traffic,
// checked against an in-bench allocator predictor. Depends on rtl/bsa_pkg.sv, rtl/bsa_if.sv and
// rtl/bitmap_slot_allocator_core.sv.
`default_nettype none
module bitmap_slot_allocator_core_tb;
  import bsa_pkg::*;

  localparam int unsigned MAP_LEN    = 128;
  localparam int unsigned SETTLE_CYC = 300;
  localparam int unsigned CYCLE_CAP  = 1000000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  slot_index;
    logic [OFFSET_W-1:0] slot_offset;
  } alloc_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bsa_in_if  in_ch ();
  bsa_out_if out_ch ();

  bitmap_slot_allocator_core #(.MAP_BYTES(MAP_LEN)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // Predictor state
  logic [7:0]        free_bits [MAP_LEN];
  logic [SLOT_W-1:0] fresh_next;
  logic [ELEM_W-1:0] slot_bytes;
  logic [NB_W-1:0]   map_len_reg;

  alloc_result_t expected_results[$];
  int            mismatch_count;
  int            cycle_count;
  bit            steady_sink;
  bit            steady_source;
  int            stall_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic clear_map();
    for (int i = 0; i < MAP_LEN; i++) free_bits[i] = 8'hff;
    fresh_next = '0;
  endtask

  // Work out the answer to one request and update the allocator state
  task automatic predict_request(input logic func, input logic [OFFSET_W-1:0] roff,
                                 output alloc_result_t res);
    logic [63:0] nb, cap, eb, rel, slot, idx;
    logic [7:0]  b, mask;
    bit          found;
    nb = (map_len_reg > MAP_LEN) ? MAP_LEN : map_len_reg;
    cap = nb * 8;
    eb = (slot_bytes == 0) ? 64'd1 : 64'(slot_bytes);
    slot = 0;
    found = 0;
    res = '0;
    if (func == FUNC_ALLOC) begin
      if (64'(fresh_next) < cap) begin
        slot = 64'(fresh_next);
        fresh_next = fresh_next + 1'b1;
        free_bits[slot >> 3] &= ~(SLOT0_BIT >> slot[2:0]);
        found = 1;
      end else begin
        // first nonzero byte, highest-numbered free slot within it
        for (int i = 0; i < nb && !found; i++) begin
          b = free_bits[i];
          for (int k = 0; k < 8 && !found; k++) begin
            if (b[k]) begin
              free_bits[i] = b & ~(8'h01 << k);
              slot = i * 8 + (7 - k);
              found = 1;
            end
          end
        end
      end
      if (found) begin
        res.slot_index  = slot[INDEX_W-1:0];
        res.slot_offset = OFFSET_W'(nb + slot * eb);
      end else begin
        res.status = ST_OOM;
      end
    end else begin
      if (64'(roff) < nb || 64'(roff) - nb >= cap * eb) begin
        res.status = ST_RANGE;
      end else begin
        rel = 64'(roff) - nb;
        if (rel % eb != 0) begin
          res.status = ST_ALIGN;
        end else begin
          idx = rel / eb;
          mask = SLOT0_BIT >> idx[2:0];
          if ((idx >> 3) >= MAP_LEN) begin
            res.status = ST_RANGE;
          end else if ((free_bits[idx >> 3] & mask) != 0) begin
            res.status = ST_FREE;
          end else begin
            free_bits[idx >> 3] |= mask;
            res.slot_index = idx[INDEX_W-1:0];
          end
        end
      end
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_source || roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result sink: random back-pressure with occasional long stalls
  always @(posedge clk) begin : sink_ready
    int roll;
    roll = $urandom_range(0, 99);
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (steady_sink) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (roll < 70) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b0;
      if (roll >= 97) stall_left <= $urandom_range(20, 60);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    alloc_result_t exp_res;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report("result with nothing expected");
      end else begin
        exp_res = expected_results.pop_front();
        if (out_ch.status !== exp_res.status)
          report($sformatf("status %0d, expected %0d", out_ch.status, exp_res.status));
        if (out_ch.slot_index !== exp_res.slot_index)
          report($sformatf("slot_index %0d, expected %0d",
                           out_ch.slot_index, exp_res.slot_index));
        if (out_ch.slot_offset !== exp_res.slot_offset)
          report($sformatf("slot_offset %0d, expected %0d",
                           out_ch.slot_offset, exp_res.slot_offset));
      end
    end
  end

  // Send one request; hold valid over back-to-back transactions
  task automatic send_request(input logic func, input logic [OFFSET_W-1:0] roff);
    alloc_result_t res;
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.func <= func;
    in_ch.region_offset <= roff;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(func, roff, res);
    expected_results.push_back(res);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every expected result has come, then let the block settle
  task automatic drain();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write one register, then release the write enable and update the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ELEMENT_BYTES) begin
      slot_bytes = val;
    end else begin
      map_len_reg = val[NB_W-1:0];
      clear_map();
    end
    @(posedge clk);
  endtask

  function automatic logic [OFFSET_W-1:0] slot_addr(input int slot);
    int nb;
    int eb;
    nb = (map_len_reg > MAP_LEN) ? MAP_LEN : map_len_reg;
    eb = (slot_bytes == 0) ? 1 : slot_bytes;
    return OFFSET_W'(nb + slot * eb);
  endfunction

  // Reset defaults: fresh allocation, reclaim, double free, out-of-range offsets
  task automatic test_defaults();
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_ALLOC, '1);
    send_request(FUNC_RECLAIM, slot_addr(1));
    send_request(FUNC_RECLAIM, slot_addr(1));
    send_request(FUNC_RECLAIM, slot_addr(1023));
    send_request(FUNC_RECLAIM, '1);
    send_request(FUNC_RECLAIM, OFFSET_W'(127));
    drain();
  endtask

  // One-byte bitmap: exhaust, reclaim, scan, misaligned and out-of-range offsets
  task automatic test_exhaustion();
    write_reg(REG_ELEMENT_BYTES, 16'd4);
    write_reg(REG_BITMAP_BYTES, 16'd1);
    repeat (9) send_request(FUNC_ALLOC, '0);
    send_request(FUNC_RECLAIM, slot_addr(2));
    send_request(FUNC_RECLAIM, slot_addr(6));
    send_request(FUNC_RECLAIM, slot_addr(3) + 1'b1);
    send_request(FUNC_RECLAIM, '0);
    send_request(FUNC_RECLAIM, slot_addr(8));
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_ALLOC, '0);
    drain();
  endtask

  // Empty bitmap, zero and maximum element size, and oversized bitmap
  task automatic test_size_corners();
    write_reg(REG_BITMAP_BYTES, 16'd0);
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_RECLAIM, '0);
    drain();
    write_reg(REG_ELEMENT_BYTES, 16'd0);
    write_reg(REG_BITMAP_BYTES, 16'd255);
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_RECLAIM, OFFSET_W'(128));
    drain();
    write_reg(REG_ELEMENT_BYTES, 16'hffff);
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_RECLAIM, slot_addr(1));
    drain();
  endtask

  // Random phases over several settings; mostly valid reclaims so the scan path runs
  task automatic test_random();
    int eb_set[8] = '{1, 3, 16'hffff, 0, 7, 1, 2, 5};
    int nb_set[8] = '{1, 2, 1, 3, 4, 0, 255, 128};
    int nb, roll, slot;
    logic [OFFSET_W-1:0] roff;
    for (int p = 0; p < 8; p++) begin
      steady_sink = (p == 2);
      steady_source = (p == 4);
      write_reg(REG_ELEMENT_BYTES, CFG_W'(eb_set[p]));
      write_reg(REG_BITMAP_BYTES, CFG_W'(nb_set[p]));
      nb = (nb_set[p] > MAP_LEN) ? MAP_LEN : nb_set[p];
      for (int n = 0; n < 62; n++) begin
        roll = $urandom_range(0, 99);
        if (p == 3 && n == 30) drain();
        if (roll < 50) begin
          send_request(FUNC_ALLOC, OFFSET_W'($urandom()));
        end else begin
          slot = (nb == 0) ? 0 : $urandom_range(0, nb * 8 - 1);
          roff = slot_addr(slot);
          if (roll < 80) roff = roff;
          else if (roll < 88) roff = roff + OFFSET_W'($urandom_range(1, 6));
          else if (roll < 92) roff = OFFSET_W'($urandom_range(0, nb));
          else roff = OFFSET_W'($urandom());
          send_request(FUNC_RECLAIM, roff);
        end
      end
      drain();
    end
    steady_sink = 0;
    steady_source = 0;
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_ALLOC;
    in_ch.region_offset <= '0;
    mismatch_count = 0;
    cycle_count = 0;
    steady_sink = 0;
    steady_source = 0;
    slot_bytes = 16'd1;
    map_len_reg = 8'd128;
    clear_map();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_exhaustion();
    test_size_corners();
    test_random();
    drain();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- bitmap_slot_allocator_core.f -----
rtl/bsa_pkg.sv
rtl/bsa_if.sv
rtl/bsa_map_ram.sv
rtl/bsa_divider.sv
rtl/bitmap_slot_allocator_core.sv
rtl/bsa_checker.sv
tb/bitmap_slot_allocator_core_tb.sv
